@@ hdl/tril_pkg.sv @@
// Shared constants, types and corner table for the trilinear interpolator.
package tril_pkg;

  localparam int FRAC_BITS   = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int LANES       = 8;

  // One axis weight spans 0 to 1.0 inclusive, so it needs one more bit.
  localparam int AXIS_BITS   = FRAC_BITS + 1;
  localparam int WEIGHT_BITS = 3 * FRAC_BITS + 1;
  localparam int ACC_BITS    = 3 * FRAC_BITS + SAMPLE_BITS;
  localparam int CODE_BITS   = 3;

  // Corner position code bits.
  localparam int CODE_X = 2;
  localparam int CODE_Y = 1;
  localparam int CODE_Z = 0;

  // Pipeline stages.
  localparam int ST_LANE_XY  = 0;
  localparam int ST_LANE_W   = 1;
  localparam int ST_LANE_P   = 2;
  localparam int ST_MRG_PAIR = 3;
  localparam int ST_MRG_OUT  = 4;
  localparam int N_STAGES    = 5;

  typedef logic [FRAC_BITS-1:0]   frac_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [ACC_BITS-1:0]    acc_t;
  typedef logic [CODE_BITS-1:0]   code_t;

  // Corner codes in request order: bit 2 = x, bit 1 = y, bit 0 = z.
  localparam code_t CORNER_CODE [LANES] = '{
    3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7
  };

  typedef struct packed {
    frac_t   frac_x;
    frac_t   frac_y;
    frac_t   frac_z;
    sample_t corner_000;
    sample_t corner_001;
    sample_t corner_010;
    sample_t corner_100;
    sample_t corner_011;
    sample_t corner_101;
    sample_t corner_110;
    sample_t corner_111;
  } tril_req_t;

  typedef struct packed {
    sample_t interpolated;
  } tril_res_t;

  typedef struct packed {
    logic [N_STAGES-1:0] en;
  } tril_ctrl_t;

endpackage

@@ hdl/tril_req_if.sv @@
// Request channel: valid/ready handshake carrying offsets and corner samples.
interface tril_req_if;
  import tril_pkg::*;

  logic      valid;
  logic      ready;
  tril_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/tril_res_if.sv @@
// Result channel: valid/ready handshake carrying the interpolated sample.
interface tril_res_if;
  import tril_pkg::*;

  logic      valid;
  logic      ready;
  tril_res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/tril_lane.sv @@
// One corner lane: builds the corner weight and multiplies it by the sample.
module tril_lane (
  input  logic                 clk_i,
  input  tril_pkg::tril_ctrl_t ctrl_i,
  input  tril_pkg::code_t      code_i,
  input  tril_pkg::frac_t      frac_x_i,
  input  tril_pkg::frac_t      frac_y_i,
  input  tril_pkg::frac_t      frac_z_i,
  input  tril_pkg::sample_t    sample_i,
  output tril_pkg::acc_t       prod_o
);
  import tril_pkg::*;

  localparam logic [AXIS_BITS-1:0] AXIS_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [AXIS_BITS-1:0]                wx, wy, wz;
  logic [2*AXIS_BITS-1:0]              wxy_d, wxy_q;
  logic [AXIS_BITS-1:0]                wz_q;
  sample_t                             sample_xy_q, sample_w_q;
  logic [3*AXIS_BITS-1:0]              weight_full;
  logic [WEIGHT_BITS-1:0]              weight_d, weight_q;
  logic [WEIGHT_BITS+SAMPLE_BITS-1:0]  prod_full;
  acc_t                                prod_d, prod_q;

  // High side of an axis takes f, low side takes 1 - f.
  assign wx = code_i[CODE_X] ? {1'b0, frac_x_i} : AXIS_ONE - {1'b0, frac_x_i};
  assign wy = code_i[CODE_Y] ? {1'b0, frac_y_i} : AXIS_ONE - {1'b0, frac_y_i};
  assign wz = code_i[CODE_Z] ? {1'b0, frac_z_i} : AXIS_ONE - {1'b0, frac_z_i};

  assign wxy_d       = wx * wy;
  assign weight_full = wxy_q * wz_q;
  // The weight never exceeds 1.0 in Q1.(3*FRAC_BITS).
  assign weight_d    = weight_full[WEIGHT_BITS-1:0];
  assign prod_full   = weight_q * sample_w_q;
  assign prod_d      = prod_full[ACC_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[ST_LANE_XY]) begin
      wxy_q       <= wxy_d;
      wz_q        <= wz;
      sample_xy_q <= sample_i;
    end
    if (ctrl_i.en[ST_LANE_W]) begin
      weight_q   <= weight_d;
      sample_w_q <= sample_xy_q;
    end
    if (ctrl_i.en[ST_LANE_P]) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;
endmodule

@@ hdl/tril_merge.sv @@
// Merge stage: two-level adder tree over the lane products, then round half up.
module tril_merge (
  input  logic                              clk_i,
  input  tril_pkg::tril_ctrl_t              ctrl_i,
  input  tril_pkg::acc_t [tril_pkg::LANES-1:0] prod_i,
  output tril_pkg::sample_t                 result_o
);
  import tril_pkg::*;

  localparam int   PAIRS      = LANES / 2;
  localparam acc_t ROUND_HALF = ACC_BITS'(1) << (3 * FRAC_BITS - 1);

  acc_t    pair_d [PAIRS];
  acc_t    pair_q [PAIRS];
  acc_t    total;
  sample_t result_q;

  // Convex weights keep every partial sum inside ACC_BITS.
  always_comb begin
    for (int i = 0; i < PAIRS; i++) begin
      pair_d[i] = prod_i[2*i] + prod_i[2*i+1];
    end
  end

  always_comb begin
    total = ROUND_HALF;
    for (int i = 0; i < PAIRS; i++) begin
      total = total + pair_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[ST_MRG_PAIR]) begin
      for (int i = 0; i < PAIRS; i++) begin
        pair_q[i] <= pair_d[i];
      end
    end
    if (ctrl_i.en[ST_MRG_OUT]) begin
      result_q <= total[3*FRAC_BITS +: SAMPLE_BITS];
    end
  end

  assign result_o = result_q;
endmodule

@@ hdl/trilinear_interpolator.sv @@
// Trilinear interpolator top level: eight weight lanes, merge tree and pipeline control.
//
// Each request carries three 10-bit offsets inside a voxel cell and the eight
// 16-bit corner samples; the block returns one 16-bit sample, the exact
// trilinear weighted sum rounded half up. The block keeps no state between
// requests. It accepts one request per cycle while the result side is ready;
// each request passes three stages in each of the eight corner lanes (axis
// weights and xy product, z product, sample product) and two in the merge tree
// (pair sums, final sum with rounding). The last merge register is the output
// register. Every stage advances on its own, so a stalled result only holds the
// stages behind it once they fill up; bubbles are squeezed out and the request
// side stays ready as long as any stage is free.
module trilinear_interpolator (
  input  logic        clk_i,
  input  logic        rst_ni,
  tril_req_if.sink    req_i,
  tril_res_if.source  result_o
);
  import tril_pkg::*;

  logic [N_STAGES-1:0] valid_d, valid_q;
  tril_ctrl_t          ctrl;
  sample_t             samples [LANES];
  acc_t [LANES-1:0]    prods;
  sample_t             result;

  // A stage loads when it is empty or when the stage after it loads.
  always_comb begin
    ctrl.en[ST_MRG_OUT] = !valid_q[ST_MRG_OUT] || result_o.ready;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      ctrl.en[k] = !valid_q[k] || ctrl.en[k+1];
    end
  end

  // Advance valid bits along with the payload; hold them when stalled.
  always_comb begin
    valid_d = valid_q;
    if (ctrl.en[ST_LANE_XY]) begin
      valid_d[ST_LANE_XY] = req_i.valid;
    end
    for (int k = 1; k < N_STAGES; k++) begin
      if (ctrl.en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign req_i.ready = ctrl.en[ST_LANE_XY];

  // Corner samples in request order; lane k uses CORNER_CODE[k].
  assign samples[0] = req_i.data.corner_000;
  assign samples[1] = req_i.data.corner_001;
  assign samples[2] = req_i.data.corner_010;
  assign samples[3] = req_i.data.corner_100;
  assign samples[4] = req_i.data.corner_011;
  assign samples[5] = req_i.data.corner_101;
  assign samples[6] = req_i.data.corner_110;
  assign samples[7] = req_i.data.corner_111;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tril_lane u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .code_i   (CORNER_CODE[g]),
      .frac_x_i (req_i.data.frac_x),
      .frac_y_i (req_i.data.frac_y),
      .frac_z_i (req_i.data.frac_z),
      .sample_i (samples[g]),
      .prod_o   (prods[g])
    );
  end

  tril_merge u_merge (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .prod_i   (prods),
    .result_o (result)
  );

  assign result_o.valid             = valid_q[ST_MRG_OUT];
  assign result_o.data.interpolated = result;

  // A ready result side lets every stage move, so requests are then never blocked.
  a_ready_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.ready |-> req_i.ready)
    else $error("request side blocked while result side ready");

  // An empty first stage always takes a request.
  a_first_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[ST_LANE_XY] |-> req_i.ready)
    else $error("request refused with first stage empty");

  // An accepted request occupies the first stage in the next cycle.
  a_req_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> valid_q[ST_LANE_XY])
    else $error("accepted request lost at first stage");

  // An item blocked behind a full output stays put.
  a_pair_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[ST_MRG_PAIR] && !ctrl.en[ST_MRG_OUT])
      |=> (valid_q[ST_MRG_PAIR] && valid_q[ST_MRG_OUT]))
    else $error("item dropped behind stalled output");
endmodule
